@@ src/ivmp_pkg.sv @@
// Shared constants for the inverse-variance mean pair pipeline.
`default_nettype none
package ivmp_pkg;
    // Usable-side selection carried down the pipeline.
    localparam logic [1:0] SEL_NONE  = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;
    localparam logic [1:0] SEL_BOTH  = 2'd3;
endpackage
`default_nettype wire

@@ src/inverse_variance_mean_pair_top.sv @@
// Top level of the inverse-variance weighted mean pipeline for two histogram bins.
// Pipeline: 3*WORD_BITS+7 register stages (4 front, 2*WORD_BITS+1 product divide,
// WORD_BITS+1 square root, 1 output).
// Throughput: one request per cycle; a stalled output freezes the whole pipeline.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module inverse_variance_mean_pair_top #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [WORD_BITS-1:0] s_left_value,
    input  wire logic [WORD_BITS-1:0] s_left_error,
    input  wire logic [WORD_BITS-1:0] s_right_value,
    input  wire logic [WORD_BITS-1:0] s_right_error,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WORD_BITS-1:0]      m_mean_value,
    output logic [WORD_BITS-2:0]      m_mean_error
);
    localparam int W        = WORD_BITS;
    localparam int DEPTH    = 3*W+1;
    localparam int MQ_DEPTH = 2*W;

    logic en;
    logic fv;
    logic [1:0] fsel;
    logic fneg;
    logic [3*W:0] fnum;
    logic [2*W:0] fden;
    logic [4*W-1:0] fprod;
    logic [W-1:0] fpv, fpe;
    logic [W-1:0] mq;
    logic [2*W-1:0] pq;
    logic [W-1:0] root;

    // side info delayed through divide+root
    logic       dv_reg   [DEPTH+1];
    logic [1:0] dsel_reg [DEPTH+1];
    logic       dneg_reg [DEPTH+1];
    logic [W-1:0] dpv_reg [DEPTH+1];
    logic [W-1:0] dpe_reg [DEPTH+1];
    logic [W-1:0] mq_reg  [MQ_DEPTH+1];

    logic            ov_reg;
    logic [W-1:0]    ovalue_reg;
    logic [W-2:0]    oerror_reg;

    assign en      = !ov_reg || m_ready;
    assign s_ready = en;

    ivmp_front #(.WORD_BITS(W)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .y1(s_left_value), .e1(s_left_error), .y2(s_right_value), .e2(s_right_error),
        .out_valid(fv), .sel(fsel), .neg(fneg), .num(fnum), .den(fden), .prod(fprod),
        .pass_value(fpv), .pass_error(fpe)
    );

    ivmp_div #(.NUM_BITS(3*W+1), .DEN_BITS(2*W+1), .Q_BITS(W)) u_mdiv (
        .aclk(aclk), .en(en), .num(fnum), .den(fden), .quo(mq)
    );

    ivmp_div #(.NUM_BITS(4*W), .DEN_BITS(2*W+1), .Q_BITS(2*W)) u_ediv (
        .aclk(aclk), .en(en), .num(fprod), .den(fden), .quo(pq)
    );

    ivmp_sqrt #(.R_BITS(W)) u_sqrt (
        .aclk(aclk), .en(en), .rad(pq), .root(root)
    );

    // mean divider finishes before the product divide and square root; delay its quotient to align
    always_ff @(posedge aclk) begin
        if (en) begin
            mq_reg[0] <= mq;
            for (int i = 0; i < MQ_DEPTH; i++) mq_reg[i+1] <= mq_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DEPTH; i++) dv_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= fv;
            for (int i = 0; i < DEPTH; i++) dv_reg[i+1] <= dv_reg[i];
            ov_reg <= dv_reg[DEPTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dsel_reg[0] <= fsel;
            dneg_reg[0] <= fneg;
            dpv_reg[0]  <= fpv;
            dpe_reg[0]  <= fpe;
            for (int i = 0; i < DEPTH; i++) begin
                dsel_reg[i+1] <= dsel_reg[i];
                dneg_reg[i+1] <= dneg_reg[i];
                dpv_reg[i+1]  <= dpv_reg[i];
                dpe_reg[i+1]  <= dpe_reg[i];
            end
            if (dsel_reg[DEPTH] == ivmp_pkg::SEL_BOTH) begin
                ovalue_reg <= dneg_reg[DEPTH] ? W'(-mq_reg[MQ_DEPTH]) : mq_reg[MQ_DEPTH];
                oerror_reg <= root[W-2:0];
            end else begin
                ovalue_reg <= dpv_reg[DEPTH];
                oerror_reg <= dpe_reg[DEPTH][W-2:0];
            end
        end
    end

    assign m_valid      = ov_reg;
    assign m_mean_value = ovalue_reg;
    assign m_mean_error = oerror_reg;

    // a stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_value))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output slot");
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        en && dv_reg[DEPTH] && dsel_reg[DEPTH] == ivmp_pkg::SEL_NONE
        |=> m_mean_value == '0 && m_mean_error == '0)
        else $error("unusable pair gave nonzero result");
endmodule
`default_nettype wire

@@ src/ivmp_front.sv @@
// Front stages: error squares, weighted numerator terms, denominator and product.
`default_nettype none
module ivmp_front #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [WORD_BITS-1:0]     y1,
    input  wire logic [WORD_BITS-1:0]     e1,
    input  wire logic [WORD_BITS-1:0]     y2,
    input  wire logic [WORD_BITS-1:0]     e2,
    output logic                          out_valid,
    output logic [1:0]                    sel,
    output logic                          neg,
    output logic [3*WORD_BITS:0]          num,
    output logic [2*WORD_BITS:0]          den,
    output logic [4*WORD_BITS-1:0]        prod,
    output logic [WORD_BITS-1:0]          pass_value,
    output logic [WORD_BITS-1:0]          pass_error
);
    localparam int W = WORD_BITS;

    // stage 1: squares and magnitudes
    logic          v1_reg;
    logic [1:0]    sel1_reg;
    logic [2*W-1:0] a_reg, b_reg;
    logic [W-1:0]  m1_reg, m2_reg, pv1_reg, pe1_reg;
    logic          n1_reg, n2_reg;
    // stage 2: half-word partial products
    logic          v2_reg;
    logic [1:0]    sel2_reg;
    logic [2*W-1:0] pl_reg, ph_reg, ql_reg, qh_reg;
    logic [2*W-1:0] abll_reg, ablh_reg, abhl_reg, abhh_reg;
    logic [2*W:0]  den2_reg;
    logic          n1b_reg, n2b_reg;
    logic [W-1:0]  pv2_reg, pe2_reg;
    // stage 3: cross products
    logic          v3_reg;
    logic [1:0]    sel3_reg;
    logic [3*W-1:0] p_reg, q_reg;
    logic [2*W:0]  den3_reg;
    logic [4*W-1:0] ab_reg;
    logic          n1c_reg, n2c_reg;
    logic [W-1:0]  pv3_reg, pe3_reg;
    // stage 4: signed numerator
    logic          v4_reg;
    logic [1:0]    sel4_reg;
    logic          neg4_reg;
    logic [3*W:0]  num4_reg;
    logic [2*W:0]  den4_reg;
    logic [4*W-1:0] ab4_reg;
    logic [W-1:0]  pv4_reg, pe4_reg;

    logic ok1, ok2;
    assign ok1 = !e1[W-1] && (e1 != '0);
    assign ok2 = !e2[W-1] && (e2 != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel1_reg <= {ok2, ok1};
            a_reg    <= (2*W)'(e1) * (2*W)'(e1);
            b_reg    <= (2*W)'(e2) * (2*W)'(e2);
            m1_reg   <= y1[W-1] ? W'(-y1) : y1;
            m2_reg   <= y2[W-1] ? W'(-y2) : y2;
            n1_reg   <= y1[W-1];
            n2_reg   <= y2[W-1];
            pv1_reg  <= ok1 ? y1 : (ok2 ? y2 : '0);
            pe1_reg  <= ok1 ? e1 : (ok2 ? e2 : '0);

            sel2_reg <= sel1_reg;
            pl_reg   <= (2*W)'(m1_reg) * (2*W)'(b_reg[W-1:0]);
            ph_reg   <= (2*W)'(m1_reg) * (2*W)'(b_reg[2*W-1:W]);
            ql_reg   <= (2*W)'(m2_reg) * (2*W)'(a_reg[W-1:0]);
            qh_reg   <= (2*W)'(m2_reg) * (2*W)'(a_reg[2*W-1:W]);
            abll_reg <= (2*W)'(a_reg[W-1:0]) * (2*W)'(b_reg[W-1:0]);
            ablh_reg <= (2*W)'(a_reg[W-1:0]) * (2*W)'(b_reg[2*W-1:W]);
            abhl_reg <= (2*W)'(a_reg[2*W-1:W]) * (2*W)'(b_reg[W-1:0]);
            abhh_reg <= (2*W)'(a_reg[2*W-1:W]) * (2*W)'(b_reg[2*W-1:W]);
            den2_reg <= (2*W+1)'(a_reg) + (2*W+1)'(b_reg);
            n1b_reg  <= n1_reg;
            n2b_reg  <= n2_reg;
            pv2_reg  <= pv1_reg;
            pe2_reg  <= pe1_reg;

            // merge the partial products at their half-word offsets
            sel3_reg <= sel2_reg;
            p_reg    <= (3*W)'(pl_reg) + ((3*W)'(ph_reg) << W);
            q_reg    <= (3*W)'(ql_reg) + ((3*W)'(qh_reg) << W);
            ab_reg   <= (4*W)'(abll_reg) + ((4*W)'(ablh_reg) << W)
                        + ((4*W)'(abhl_reg) << W) + ((4*W)'(abhh_reg) << (2*W));
            den3_reg <= den2_reg;
            n1c_reg  <= n1b_reg;
            n2c_reg  <= n2b_reg;
            pv3_reg  <= pv2_reg;
            pe3_reg  <= pe2_reg;

            sel4_reg <= sel3_reg;
            if (n1c_reg == n2c_reg) begin
                num4_reg <= (3*W+1)'(p_reg) + (3*W+1)'(q_reg);
                neg4_reg <= n1c_reg;
            end else if (p_reg >= q_reg) begin
                num4_reg <= (3*W+1)'(p_reg - q_reg);
                neg4_reg <= n1c_reg;
            end else begin
                num4_reg <= (3*W+1)'(q_reg - p_reg);
                neg4_reg <= n2c_reg;
            end
            den4_reg <= den3_reg;
            ab4_reg  <= ab_reg;
            pv4_reg  <= pv3_reg;
            pe4_reg  <= pe3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign sel        = sel4_reg;
    assign neg        = neg4_reg;
    assign num        = num4_reg;
    assign den        = den4_reg;
    assign prod       = ab4_reg;
    assign pass_value = pv4_reg;
    assign pass_error = pe4_reg;
endmodule
`default_nettype wire

@@ src/ivmp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module ivmp_div #(
    parameter int NUM_BITS = 97,
    parameter int DEN_BITS = 65,
    parameter int Q_BITS   = 32
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic [Q_BITS-1:0]        quo
);
    // Quotient is known to fit Q_BITS, so the top NUM_BITS-Q_BITS bits start the remainder.
    localparam int RB = DEN_BITS + 1;
    logic [RB-1:0]       rem_reg [Q_BITS+1];
    logic [NUM_BITS-1:0] n_reg   [Q_BITS+1];
    logic [DEN_BITS-1:0] d_reg   [Q_BITS+1];
    logic [Q_BITS-1:0]   q_reg   [Q_BITS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RB'(num >> Q_BITS);
            n_reg[0]   <= num;
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < Q_BITS; k++) begin : g_step
        logic [RB-1:0] trial;
        assign trial = {rem_reg[k][RB-2:0], n_reg[k][Q_BITS-1-k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k+1] <= n_reg[k];
                d_reg[k+1] <= d_reg[k];
                if (trial >= RB'(d_reg[k])) begin
                    rem_reg[k+1] <= trial - RB'(d_reg[k]);
                    q_reg[k+1]   <= q_reg[k] | (Q_BITS'(1) << (Q_BITS-1-k));
                end else begin
                    rem_reg[k+1] <= trial;
                    q_reg[k+1]   <= q_reg[k];
                end
            end
        end
    end

    assign quo = q_reg[Q_BITS];
endmodule
`default_nettype wire

@@ src/ivmp_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module ivmp_sqrt #(
    parameter int R_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic [2*R_BITS-1:0] rad,
    output logic [R_BITS-1:0]        root
);
    logic [2*R_BITS-1:0] x_reg [R_BITS+1];
    logic [R_BITS-1:0]   r_reg [R_BITS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= rad;
            r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < R_BITS; k++) begin : g_bit
        logic [R_BITS-1:0]   cand;
        logic [2*R_BITS-1:0] sq;
        assign cand = r_reg[k] | (R_BITS'(1) << (R_BITS-1-k));
        // candidate square from previous root: r^2 + 2r*2^j + 2^2j, written as one square
        assign sq = (2*R_BITS)'(cand) * (2*R_BITS)'(cand);
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1] <= x_reg[k];
                r_reg[k+1] <= (sq <= x_reg[k]) ? cand : r_reg[k];
            end
        end
    end

    assign root = r_reg[R_BITS];
endmodule
`default_nettype wire
